@@ design/cau_pkg.sv @@
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies; imported by cau_div and complex_arithmetic_unit.
package cau_pkg;

  localparam int unsigned FRAC_BITS = 16;
  // Quotient bits kept by the divider; anything larger saturates anyway.
  localparam int unsigned QBITS     = 33;
  localparam int unsigned NUM_W     = 64 + FRAC_BITS;
  localparam int unsigned CMP_W     = 64 + QBITS;
  localparam int unsigned DIV_LAT   = QBITS + 1;
  // Input stage, products, sums, sign/magnitude, divider, output register.
  localparam int unsigned N_STAGES  = 4 + DIV_LAT + 1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               overflow;
    logic               div_zero;
  } cau_rsp_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // Saturate a sign and magnitude pair to 32-bit two's complement.
  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end else if (mag > 64'h8000_0000) begin
      r.ovf = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.val = (~mag[31:0]) + 32'd1;
    end
    return r;
  endfunction

endpackage

@@ design/cau_div.sv @@
// Pipelined restoring divider: floor(mag * 2^FRAC_BITS / den), one quotient
// bit per stage, with a flag for quotients too large to keep. Uses cau_pkg.
module cau_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [63:0]               mag_i,
  input  logic [63:0]               den_i,
  output logic [cau_pkg::QBITS-1:0] q_o,
  output logic                      big_o
);
  import cau_pkg::*;

  logic [NUM_W-1:0] num;
  logic             big_d;

  logic [63:0]       rem_q [QBITS];
  logic [QBITS-1:0]  lo_q  [QBITS];
  logic [63:0]       den_q [QBITS];
  logic [QBITS-1:0]  q_q   [QBITS+1];
  logic              big_q [QBITS+1];

  assign num   = NUM_W'(mag_i) << FRAC_BITS;
  // A quotient of 2^QBITS or more only ever saturates.
  assign big_d = CMP_W'(num) >= (CMP_W'(den_i) << QBITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 64'(num >> QBITS);
      lo_q[0]  <= num[QBITS-1:0];
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      big_q[0] <= big_d;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign trial = {rem_q[k], lo_q[k][QBITS-1-k]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]   <= {q_q[k][QBITS-2:0], ge};
        big_q[k+1] <= big_q[k];
      end
    end

    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[63:0] : trial[63:0];
          lo_q[k+1]  <= lo_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign q_o   = q_q[QBITS];
  assign big_o = big_q[QBITS];

endmodule

@@ design/complex_arithmetic_unit.sv @@
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// One request is accepted every cycle while the pipeline is not held.
// The pipeline depth is set by the divider, one quotient bit a stage.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the stage valid bits only; the data registers are not reset.
module complex_arithmetic_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cau_pkg::cau_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cau_pkg::cau_rsp_t out_rsp_o
);
  import cau_pkg::*;

  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
  } side_t;

  logic en;
  logic [N_STAGES-1:0] vld_q;

  assign en          = ~vld_q[N_STAGES-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[N_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGES-2:0], in_valid_i};
    end
  end

  // Stage 1: capture the request.
  cau_req_t s1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_req_i;
    end
  end

  // Stage 2: all products, plus the finished add/subtract result.
  logic signed [32:0] as_re, as_im;
  logic [32:0]        as_re_mag, as_im_mag;
  sat_t               as_re_sat, as_im_sat;

  always_comb begin
    if (s1_q.mode == MODE_SUB) begin
      as_re = 33'(s1_q.a_re) - 33'(s1_q.b_re);
      as_im = 33'(s1_q.a_im) - 33'(s1_q.b_im);
    end else begin
      as_re = 33'(s1_q.a_re) + 33'(s1_q.b_re);
      as_im = 33'(s1_q.a_im) + 33'(s1_q.b_im);
    end
    as_re_mag = as_re[32] ? (~as_re) + 33'd1 : as_re;
    as_im_mag = as_im[32] ? (~as_im) + 33'd1 : as_im;
    as_re_sat = sat32(as_re[32], 64'(as_re_mag));
    as_im_sat = sat32(as_im[32], 64'(as_im_mag));
  end

  mode_e              s2_mode_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, d_rr_q, d_ii_q;
  sat_t               s2_re_q, s2_im_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mode_q <= s1_q.mode;
      p_rr_q    <= s1_q.a_re * s1_q.b_re;
      p_ii_q    <= s1_q.a_im * s1_q.b_im;
      p_ri_q    <= s1_q.a_re * s1_q.b_im;
      p_ir_q    <= s1_q.a_im * s1_q.b_re;
      d_rr_q    <= s1_q.b_re * s1_q.b_re;
      d_ii_q    <= s1_q.b_im * s1_q.b_im;
      s2_re_q   <= as_re_sat;
      s2_im_q   <= as_im_sat;
    end
  end

  // Stage 3: exact sums of the products and the denominator |b|^2.
  mode_e              s3_mode_q;
  logic signed [65:0] sum_re_q, sum_im_q;
  logic [63:0]        den_q;
  sat_t               s3_re_q, s3_im_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mode_q <= s2_mode_q;
      if (s2_mode_q == MODE_DIV) begin
        sum_re_q <= 66'(p_rr_q) + 66'(p_ii_q);
        sum_im_q <= 66'(p_ir_q) - 66'(p_ri_q);
      end else begin
        sum_re_q <= 66'(p_rr_q) - 66'(p_ii_q);
        sum_im_q <= 66'(p_ri_q) + 66'(p_ir_q);
      end
      den_q   <= 64'(d_rr_q) + 64'(d_ii_q);
      s3_re_q <= s2_re_q;
      s3_im_q <= s2_im_q;
    end
  end

  // Stage 4: sign and magnitude; the divide-by-zero check.
  mode_e       s4_mode_q;
  logic        s4_neg_re_q, s4_neg_im_q, s4_dz_q;
  logic [63:0] s4_mag_re_q, s4_mag_im_q, s4_den_q;
  sat_t        s4_re_q, s4_im_q;
  logic [65:0] abs_re, abs_im;

  assign abs_re = sum_re_q[65] ? (~sum_re_q) + 66'd1 : sum_re_q;
  assign abs_im = sum_im_q[65] ? (~sum_im_q) + 66'd1 : sum_im_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mode_q   <= s3_mode_q;
      s4_neg_re_q <= sum_re_q[65];
      s4_neg_im_q <= sum_im_q[65];
      s4_mag_re_q <= abs_re[63:0];
      s4_mag_im_q <= abs_im[63:0];
      s4_den_q    <= den_q;
      s4_dz_q     <= (s3_mode_q == MODE_DIV) && (den_q == 64'd0);
      s4_re_q     <= s3_re_q;
      s4_im_q     <= s3_im_q;
    end
  end

  // Results other than divide are final here and ride alongside the divider.
  sat_t  mul_re_sat, mul_im_sat;
  side_t side_d;

  always_comb begin
    mul_re_sat    = sat32(s4_neg_re_q, s4_mag_re_q >> FRAC_BITS);
    mul_im_sat    = sat32(s4_neg_im_q, s4_mag_im_q >> FRAC_BITS);
    side_d.is_div = (s4_mode_q == MODE_DIV);
    side_d.dz     = s4_dz_q;
    side_d.neg_re = s4_neg_re_q;
    side_d.neg_im = s4_neg_im_q;
    if (s4_mode_q == MODE_MUL) begin
      side_d.re  = mul_re_sat.val;
      side_d.im  = mul_im_sat.val;
      side_d.ovf = mul_re_sat.ovf | mul_im_sat.ovf;
    end else begin
      side_d.re  = s4_re_q.val;
      side_d.im  = s4_im_q.val;
      side_d.ovf = s4_re_q.ovf | s4_im_q.ovf;
    end
  end

  side_t side_q [DIV_LAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [QBITS-1:0] q_re, q_im;
  logic             big_re, big_im;

  cau_div u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (s4_mag_re_q),
    .den_i (s4_den_q),
    .q_o   (q_re),
    .big_o (big_re)
  );

  cau_div u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (s4_mag_im_q),
    .den_i (s4_den_q),
    .q_o   (q_im),
    .big_o (big_im)
  );

  // Output stage: saturate the quotients and pick the result.
  side_t    last;
  sat_t     div_re_sat, div_im_sat;
  cau_rsp_t rsp_d, rsp_q;

  always_comb begin
    last       = side_q[DIV_LAT-1];
    div_re_sat = sat32(last.neg_re, big_re ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(q_re));
    div_im_sat = sat32(last.neg_im, big_im ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(q_im));
    rsp_d.div_zero = 1'b0;
    if (!last.is_div) begin
      rsp_d.res_re   = last.re;
      rsp_d.res_im   = last.im;
      rsp_d.overflow = last.ovf;
    end else if (last.dz) begin
      rsp_d.res_re   = '0;
      rsp_d.res_im   = '0;
      rsp_d.overflow = 1'b0;
      rsp_d.div_zero = 1'b1;
    end else begin
      rsp_d.res_re   = div_re_sat.val;
      rsp_d.res_im   = div_im_sat.val;
      rsp_d.overflow = div_re_sat.ovf | div_im_sat.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule
